### rtl/core/swd_pkg.sv
// swd_pkg: sizes, register codes, state codes and small helpers of the stillness window detector
// used by swd_div and stillness_window_detector_top; no dependencies
package swd_pkg;

  localparam int WINDOW_DEPTH = 51;
  localparam int SAMPLE_BITS  = 16;

  localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int LANES   = 3;
  localparam int ENTRY_W = LANES * SAMPLE_BITS;

  localparam int THR_W      = 15;
  localparam int FILL_CFG_W = 6;
  localparam int LIM_W      = 2 * THR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  localparam int UNSEEN_W = 16;
  localparam int CONF_W   = 8;
  localparam int FILL_W   = 6;

  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int CMP_W   = (CNT_W > FILL_CFG_W) ? CNT_W : FILL_CFG_W;
  localparam int DEV_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int QCMP_W  = (SQ_W + 1 > LIM_W) ? SQ_W + 1 : LIM_W;

  localparam logic [THR_W-1:0]      SPEED_THR_RST = THR_W'(10);
  localparam logic [THR_W-1:0]      ANGLE_THR_RST = THR_W'(256);
  localparam logic [FILL_CFG_W-1:0] MIN_FILL_RST  = FILL_CFG_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_DEV = 2'd0,
    REG_ANGLE_DEV = 2'd1,
    REG_MIN_FILL  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_CHK,
    ST_DONE
  } state_t;

  // step a window slot with wrap at the depth
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] sext_sum(input logic [SAMPLE_BITS-1:0] v);
    return {{(SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  // exact magnitude of the difference of two samples
  function automatic logic [SAMPLE_BITS-1:0] abs_diff(input logic [SAMPLE_BITS-1:0] a,
                                                      input logic [SAMPLE_BITS-1:0] b);
    logic [SAMPLE_BITS:0] d;
    logic [SAMPLE_BITS:0] m;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    m = d[SAMPLE_BITS] ? (~d + 1'b1) : d;
    return m[SAMPLE_BITS-1:0];
  endfunction

endpackage

### rtl/core/stillness_window_detector_top.sv
// stillness_window_detector_top: sliding-window stillness check with filter reset request
// depends on swd_pkg, swd_ram and swd_div
//
// Each frame transaction pushes (vel_x, vel_y, ang_vel) into a window of WINDOW_DEPTH entries
// held in one ram; when the window is full the oldest entry is overwritten. Once the window
// holds at least min_fill entries, one sweep over the ram sums the three samples, a three-lane
// bit-serial divider forms the means (truncated toward zero), and a second sweep checks every
// entry's squared velocity deviation against speed_dev_threshold squared and its angular
// deviation against angle_dev_threshold. A still window is emptied and reset_request is set.
// vanished_frames counts consecutive zero-confidence frames and saturates. One frame is in
// work at a time: with the check running, its time is set by two ram sweeps over the window's
// entries at one entry a cycle and by the divider at one quotient bit a cycle; without the
// check the frame goes straight to its result. The next frame is taken while a finished
// result still waits on out_stall. Window entries are never read before they are written,
// so the ram needs no clearing after reset.
module stillness_window_detector_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [swd_pkg::SAMPLE_BITS-1:0] vel_x,
  input  logic signed [swd_pkg::SAMPLE_BITS-1:0] vel_y,
  input  logic signed [swd_pkg::SAMPLE_BITS-1:0] ang_vel,
  input  logic [swd_pkg::CONF_W-1:0]             confidence,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   reset_request,
  output logic [swd_pkg::UNSEEN_W-1:0]           vanished_frames,
  output logic [swd_pkg::CONF_W-1:0]             in_sight,
  output logic [swd_pkg::FILL_W-1:0]             window_fill,
  input  logic                                   cfg_wr_en,
  input  logic [swd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [swd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import swd_pkg::*;

  // configuration
  logic [THR_W-1:0]      speed_thr;
  logic [THR_W-1:0]      angle_thr;
  logic [FILL_CFG_W-1:0] min_fill;

  // control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  fill;
  logic [ADDR_W-1:0] oldest;
  logic [UNSEEN_W-1:0] unseen;
  logic [CNT_W-1:0]  issue_cnt;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_vld;
  logic              d_vld;
  logic              q_vld;

  // per-frame datapath
  logic [CONF_W-1:0]       conf_q;
  logic                    chk_ran;
  logic                    fail;
  logic [LIM_W-1:0]        lim2;
  logic signed [SUM_W-1:0] acc [LANES];
  logic signed [SAMPLE_BITS-1:0] mean [LANES];
  logic [SAMPLE_BITS-1:0]  dx, dy;
  logic [SQ_W-1:0]         qx, qy;

  // ram and divider hookup
  logic [ENTRY_W-1:0]      rd_data;
  logic [SAMPLE_BITS-1:0]  rx, ry, rw;
  logic                    div_start;
  logic                    div_done;
  logic signed [SAMPLE_BITS-1:0] div_q [LANES];

  // push bookkeeping
  logic              accept;
  logic              full;
  logic [ADDR_W:0]   slot_sum;
  logic [ADDR_W:0]   slot_wrap;
  logic [ADDR_W-1:0] wr_slot;
  logic [CNT_W-1:0]  fill_push;
  logic [ADDR_W-1:0] oldest_push;
  logic              run_check;
  logic              issue;
  logic              out_load;
  logic              still;
  logic [SAMPLE_BITS-1:0] dw_abs;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign full      = (fill == CNT_W'(WINDOW_DEPTH));
  assign slot_sum  = (ADDR_W + 1)'(oldest) + (ADDR_W + 1)'(fill);
  assign slot_wrap = (slot_sum >= (ADDR_W + 1)'(WINDOW_DEPTH))
                     ? slot_sum - (ADDR_W + 1)'(WINDOW_DEPTH) : slot_sum;
  assign wr_slot     = full ? oldest : slot_wrap[ADDR_W-1:0];
  assign fill_push   = full ? fill : fill + 1'b1;
  assign oldest_push = full ? next_slot(oldest) : oldest;
  assign run_check   = CMP_W'(fill_push) >= CMP_W'(min_fill);

  assign issue = ((state == ST_SUM) || (state == ST_CHK)) && (issue_cnt != '0);
  assign still = chk_ran && !fail;

  assign rx = rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign ry = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rw = rd_data[SAMPLE_BITS-1:0];

  assign dw_abs = abs_diff(rw, mean[2]);

  swd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk    (clk),
    .wr_en  (accept),
    .wr_addr(wr_slot),
    .wr_data({vel_x, vel_y, ang_vel}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  swd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc),
    .divisor (fill),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = run_check ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        // sum sweep drained
        if ((issue_cnt == '0) && !rd_vld) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        // deviation pipeline drained
        if ((issue_cnt == '0) && !rd_vld && !d_vld && !q_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // output register free or emptied this cycle
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      speed_thr <= SPEED_THR_RST;
      angle_thr <= ANGLE_THR_RST;
      min_fill  <= MIN_FILL_RST;
      fill      <= '0;
      oldest    <= '0;
      unseen    <= '0;
      issue_cnt <= '0;
      rd_vld    <= 1'b0;
      d_vld     <= 1'b0;
      q_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SPEED_DEV: speed_thr <= cfg_data[THR_W-1:0];
          REG_ANGLE_DEV: angle_thr <= cfg_data[THR_W-1:0];
          REG_MIN_FILL:  min_fill  <= cfg_data[FILL_CFG_W-1:0];
          default: ;
        endcase
      end

      // sweep address generator, shared by both passes
      rd_vld <= issue;
      if (issue) begin
        issue_cnt <= issue_cnt - 1'b1;
      end
      if (accept) begin
        fill      <= fill_push;
        oldest    <= oldest_push;
        issue_cnt <= fill_push;
      end
      if ((state == ST_DIV) && div_done) begin
        issue_cnt <= fill;
      end

      d_vld <= (state == ST_CHK) && rd_vld;
      q_vld <= d_vld;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        if (still) begin
          fill   <= '0;
          oldest <= '0;
        end
        if (conf_q == '0) begin
          if (unseen != '1) begin
            unseen <= unseen + 1'b1;
          end
        end else begin
          unseen <= '0;
        end
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr <= next_slot(rd_addr);
    end
    if (accept) begin
      conf_q  <= confidence;
      chk_ran <= run_check;
      fail    <= 1'b0;
      lim2    <= LIM_W'(speed_thr) * LIM_W'(speed_thr);
      rd_addr <= oldest_push;
      for (int i = 0; i < LANES; i++) begin
        acc[i] <= '0;
      end
    end

    if ((state == ST_SUM) && rd_vld) begin
      acc[0] <= acc[0] + sext_sum(rx);
      acc[1] <= acc[1] + sext_sum(ry);
      acc[2] <= acc[2] + sext_sum(rw);
    end

    if ((state == ST_DIV) && div_done) begin
      mean    <= div_q;
      rd_addr <= oldest;
    end

    // stage 1: deviations
    if ((state == ST_CHK) && rd_vld) begin
      dx <= abs_diff(rx, mean[0]);
      dy <= abs_diff(ry, mean[1]);
    end

    // stage 2: squares
    if (d_vld) begin
      qx <= SQ_W'(dx) * SQ_W'(dx);
      qy <= SQ_W'(dy) * SQ_W'(dy);
    end

    // angular limit in stage 1, squared speed limit in stage 3
    if (((state == ST_CHK) && rd_vld && (DEV_W'(dw_abs) > DEV_W'(angle_thr)))
        || (q_vld && ((QCMP_W'(qx) + QCMP_W'(qy)) > QCMP_W'(lim2)))) begin
      fail <= 1'b1;
    end

    if (out_load) begin
      reset_request   <= still;
      in_sight        <= conf_q;
      window_fill     <= still ? '0 : FILL_W'(fill);
      if (conf_q == '0) begin
        vanished_frames <= (unseen != '1) ? unseen + 1'b1 : unseen;
      end else begin
        vanished_frames <= '0;
      end
    end
  end

endmodule

### rtl/core/swd_ram.sv
// swd_ram: generic single-port-write, single-port-read ram with registered read data
// no dependencies
module swd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/swd_div.sv
// swd_div: three-lane restoring divider, one quotient bit per cycle, truncates toward zero
// depends on swd_pkg
module swd_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [swd_pkg::SUM_W-1:0]    dividend [swd_pkg::LANES],
  input  logic [swd_pkg::CNT_W-1:0]           divisor,
  output logic                                done,
  output logic signed [swd_pkg::SAMPLE_BITS-1:0] quotient [swd_pkg::LANES]
);
  import swd_pkg::*;

  localparam int CW = $clog2(SUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [CNT_W-1:0] dvsr;
  logic [SUM_W-1:0] quo  [LANES];
  logic [CNT_W-1:0] rem  [LANES];
  logic             neg  [LANES];
  logic [SUM_W-1:0] quo_next [LANES];
  logic [CNT_W-1:0] rem_next [LANES];

  always_comb begin
    logic [CNT_W:0] trial;
    for (int i = 0; i < LANES; i++) begin
      trial = {rem[i], quo[i][SUM_W-1]};
      if (trial >= {1'b0, dvsr}) begin
        rem_next[i] = CNT_W'(trial - {1'b0, dvsr});
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[CNT_W-1:0];
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      for (int i = 0; i < LANES; i++) begin
        neg[i] <= dividend[i][SUM_W-1];
        quo[i] <= dividend[i][SUM_W-1] ? (~dividend[i] + 1'b1) : dividend[i];
        rem[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < LANES; i++) begin
        quo[i] <= quo_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  // quotient magnitude never exceeds half the sample range
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      quotient[i] = neg[i] ? (~quo[i][SAMPLE_BITS-1:0] + 1'b1) : quo[i][SAMPLE_BITS-1:0];
    end
  end

endmodule
